// File: sv/workload_split_autotuner_assert.svh
// Assertion macros shared by the autotuner modules.
`ifndef WORKLOAD_SPLIT_AUTOTUNER_ASSERT_SVH
`define WORKLOAD_SPLIT_AUTOTUNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/wsa_pkg.sv
package wsa_pkg;

    // Field widths
    localparam int OPCODE_W   = 1;
    localparam int IT_W       = 31;
    localparam int MT_W       = 32;
    localparam int WL_W       = 7;
    localparam int MODE_W     = 2;
    localparam int SP_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Bits of a measured time that take part in tuning
    localparam int TIME_BITS = 32;

    // Shared serial divider: dividend is an iteration index or 100 * time,
    // divisor is period + 1 or best + time.
    localparam int DIV_DW    = (TIME_BITS + 7 > IT_W) ? TIME_BITS + 7 : IT_W;
    localparam int DIV_VW    = (TIME_BITS + 1 > SP_W + 1) ? TIME_BITS + 1 : SP_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_DW + 1);

    // Share constants
    localparam logic [WL_W-1:0] SHARE_FULL  = WL_W'(100);
    localparam logic [WL_W-1:0] SHARE_HALF  = WL_W'(50);
    localparam logic [WL_W-1:0] SHARE_STEP  = WL_W'(5);
    localparam logic [WL_W-1:0] SHARE_FLOOR = WL_W'(30);
    localparam logic [WL_W-1:0] SHARE_MIN   = WL_W'(1);
    localparam logic [WL_W-1:0] PROBE_FIRST = WL_W'(75);
    localparam logic [WL_W-1:0] BR_LOW_INIT = WL_W'(1);

    localparam logic [SP_W-1:0] PERIOD_RESET = SP_W'(10);

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_RESTART = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_ITER    = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 2'd0,
        MODE_STEP   = 2'd1,
        MODE_RATIO  = 2'd2,
        MODE_BISECT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_TUNE,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic restart;
        logic div_start;
        logic div_step;
        logic tune;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic need_div;
        logic direct_tune;
        logic div_done;
        logic hit;
    } t_status;

endpackage

// File: sv/wsa_intf.sv
interface wsa_in_if import wsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [IT_W-1:0]     iteration;
    logic [MT_W-1:0]     measured_time;

    modport source (output valid, opcode, iteration, measured_time, input ready);
    modport sink   (input valid, opcode, iteration, measured_time, output ready);
endinterface

interface wsa_out_if import wsa_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [WL_W-1:0] workload;
    logic            tuned_now;
    logic            stopped;

    modport source (output valid, workload, tuned_now, stopped, input ready);
    modport sink   (input valid, workload, tuned_now, stopped, output ready);
endinterface

interface wsa_cfg_if import wsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/wsa_ctrl.sv
`include "workload_split_autotuner_assert.svh"

module wsa_ctrl import wsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.restart) begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_WRITE;
                end else if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_status.direct_tune) begin
                    o_cmd.tune = 1'b1;
                    n_state    = S_WRITE;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_TUNE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_TUNE: begin
                o_cmd.tune = i_status.hit;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `WSA_ASSERT_IMP(a_load_into_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready, "result overwrote a waiting result")
    `WSA_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second request taken while busy")

endmodule

// File: sv/wsa_dp.sv
`include "workload_split_autotuner_assert.svh"

module wsa_dp import wsa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    wsa_cfg_if.sink             i_cfg,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [IT_W-1:0]     i_iteration,
    input  logic [MT_W-1:0]     i_measured_time,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic [WL_W-1:0]     o_workload,
    output logic                o_tuned_now,
    output logic                o_stopped
);

    localparam int BR_W = WL_W + 3;

    function automatic logic signed [BR_W-1:0] ext_br(input logic [WL_W-1:0] v);
        ext_br = $signed({{(BR_W-WL_W){1'b0}}, v});
    endfunction

    // Halve, rounding toward zero
    function automatic logic signed [BR_W-1:0] half_tz(input logic signed [BR_W-1:0] x);
        logic signed [BR_W-1:0] adj;
        adj     = x + $signed({{(BR_W-1){1'b0}}, x[BR_W-1]});
        half_tz = adj >>> 1;
    endfunction

    // Configuration
    t_mode            r_mode, n_mode;
    logic [SP_W-1:0]  r_period, n_period;

    // Request held for the whole item
    logic [OPCODE_W-1:0]  r_opcode;
    logic [IT_W-1:0]      r_iter;
    logic [TIME_BITS-1:0] r_time;

    // Tuning state
    logic                 r_stop, n_stop;
    logic                 r_tuned, n_tuned;
    logic [WL_W-1:0]      r_share, n_share;
    logic [TIME_BITS-1:0] r_quick_time, n_quick_time;
    logic [WL_W-1:0]      r_best_share, n_best_share;
    logic [WL_W-1:0]      r_low, n_low;
    logic [WL_W-1:0]      r_mid, n_mid;
    logic [WL_W-1:0]      r_high, n_high;
    logic [WL_W-1:0]      r_probe, n_probe;
    logic [TIME_BITS-1:0] r_mid_time, n_mid_time;

    // Serial divider
    logic [DIV_DW-1:0]    r_dvd;
    logic [DIV_VW-1:0]    r_dvs;
    logic [DIV_VW-1:0]    r_rem;
    logic [WL_W-1:0]      r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_div_ratio;
    logic [DIV_VW:0]      rem_sh;
    logic [DIV_VW:0]      dvs_ext;
    logic                 rem_ge;

    // Output register
    logic [WL_W-1:0] r_out_share;
    logic            r_out_tuned;
    logic            r_out_stop;

    // Decode
    logic is_iter, live, ratio_point, best_zero;

    // Step-down
    logic                 sd_upd, sd_end;
    logic [TIME_BITS-1:0] sd_quick_time;
    logic [WL_W-1:0]      sd_best_share, sd_share;

    // Ratio
    logic                 ra_first;
    logic [TIME_BITS-1:0] ra_quick_time;
    logic [WL_W-1:0]      ra_best_share, ra_share;

    // Bisection
    logic signed [BR_W-1:0] b_lo, b_mid, b_hi, b_pr, b_nx, g_hi, g_lo;
    logic [TIME_BITS-1:0]   bs_mid_time;
    logic [WL_W-1:0]        bs_probe;
    logic                   bs_stop;

    assign i_cfg.ready = 1'b1;

    assign is_iter     = (r_opcode == OP_ITER);
    assign live        = is_iter && !r_stop;
    assign best_zero   = (r_quick_time == '0);
    assign ratio_point = (r_iter == IT_W'(r_period >> 1)) || (r_iter == IT_W'(r_period));

    always_comb begin
        o_status.restart     = !is_iter;
        o_status.need_div    = live && ((r_mode == MODE_STEP) || (r_mode == MODE_BISECT) ||
                               ((r_mode == MODE_RATIO) && ratio_point && !best_zero));
        o_status.direct_tune = live && (r_mode == MODE_RATIO) && ratio_point && best_zero;
        o_status.div_done    = (r_cnt == '0);
        o_status.hit         = r_div_ratio || (r_rem == DIV_VW'(r_period));
    end

    // Step-down: keep the best, lower by one step, fall back once the next step would drop below the floor
    always_comb begin
        sd_upd        = best_zero || (r_time < r_quick_time);
        sd_quick_time = sd_upd ? r_time : r_quick_time;
        sd_best_share = sd_upd ? r_share : r_best_share;
        sd_end        = (r_share < (SHARE_FLOOR + SHARE_STEP));
        sd_share      = sd_end ? sd_best_share : (r_share - SHARE_STEP);
    end

    // Ratio: first point records the time, second takes the quotient
    always_comb begin
        ra_first      = best_zero;
        ra_quick_time = ra_first ? r_time : r_quick_time;
        ra_best_share = ra_first ? r_best_share : r_quo;
        ra_share      = ra_first ? SHARE_MIN : r_quo;
    end

    // Bisection: narrow the bracket around the faster point, probe the wider gap
    always_comb begin
        b_lo        = ext_br(r_low);
        b_mid       = ext_br(r_mid);
        b_hi        = ext_br(r_high);
        b_pr        = ext_br(r_probe);
        bs_mid_time = r_mid_time;
        if (r_mid_time != '0) begin
            if (r_time < r_mid_time) begin
                if (b_pr < b_mid) begin
                    b_hi = b_mid;
                end else begin
                    b_lo = b_mid;
                end
                b_mid       = b_pr;
                bs_mid_time = r_time;
            end else begin
                if (b_pr < b_mid) begin
                    b_lo = b_pr;
                end else begin
                    b_hi = b_pr;
                end
            end
        end else begin
            bs_mid_time = r_time;
        end
        g_hi = b_hi - b_mid;
        g_lo = b_mid - b_lo;
        if (g_hi > g_lo) begin
            b_nx = b_mid + half_tz(g_hi);
        end else begin
            b_nx = b_lo + half_tz(g_lo + $signed(BR_W'(1)));
        end
        bs_probe = (r_mid_time == '0) ? PROBE_FIRST : b_nx[WL_W-1:0];
        bs_stop  = (g_hi == $signed(BR_W'(1))) && (g_lo == $signed(BR_W'(1)));
    end

    always_comb begin
        n_mode       = r_mode;
        n_period     = r_period;
        n_stop       = r_stop;
        n_tuned      = r_tuned;
        n_share      = r_share;
        n_quick_time = r_quick_time;
        n_best_share = r_best_share;
        n_low        = r_low;
        n_mid        = r_mid;
        n_high       = r_high;
        n_probe      = r_probe;
        n_mid_time   = r_mid_time;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE:   n_mode   = t_mode'(i_cfg.data[MODE_W-1:0]);
                REG_PERIOD: n_period = i_cfg.data[SP_W-1:0];
                default:    ;
            endcase
        end

        if (i_cmd.load) begin
            n_tuned = 1'b0;
        end

        if (i_cmd.restart) begin
            n_stop       = 1'b0;
            n_tuned      = 1'b0;
            n_share      = (r_mode == MODE_BISECT) ? SHARE_HALF : SHARE_FULL;
            n_quick_time = '0;
            n_best_share = '0;
            n_low        = BR_LOW_INIT;
            n_mid        = SHARE_HALF;
            n_high       = SHARE_FULL;
            n_probe      = SHARE_HALF;
            n_mid_time   = '0;
        end else if (i_cmd.tune) begin
            n_tuned = 1'b1;
            unique case (r_mode)
                MODE_STEP: begin
                    n_quick_time = sd_quick_time;
                    n_best_share = sd_best_share;
                    n_share      = sd_share;
                    n_stop       = sd_end;
                end
                MODE_RATIO: begin
                    n_quick_time = ra_quick_time;
                    n_best_share = ra_best_share;
                    n_share      = ra_share;
                    n_stop       = r_stop || (ra_best_share != '0);
                end
                MODE_BISECT: begin
                    n_low      = b_lo[WL_W-1:0];
                    n_mid      = b_mid[WL_W-1:0];
                    n_high     = b_hi[WL_W-1:0];
                    n_probe    = bs_probe;
                    n_share    = bs_probe;
                    n_mid_time = bs_mid_time;
                    n_stop     = r_stop || bs_stop;
                end
                MODE_OFF: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_STEP;
            r_period     <= PERIOD_RESET;
            r_stop       <= 1'b0;
            r_tuned      <= 1'b0;
            r_share      <= SHARE_FULL;
            r_quick_time <= '0;
            r_best_share <= '0;
            r_low        <= BR_LOW_INIT;
            r_mid        <= SHARE_HALF;
            r_high       <= SHARE_FULL;
            r_probe      <= SHARE_HALF;
            r_mid_time   <= '0;
        end else begin
            r_mode       <= n_mode;
            r_period     <= n_period;
            r_stop       <= n_stop;
            r_tuned      <= n_tuned;
            r_share      <= n_share;
            r_quick_time <= n_quick_time;
            r_best_share <= n_best_share;
            r_low        <= n_low;
            r_mid        <= n_mid;
            r_high       <= n_high;
            r_probe      <= n_probe;
            r_mid_time   <= n_mid_time;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_iter   <= i_iteration;
            r_time   <= TIME_BITS'(i_measured_time);
        end
    end

    // Restoring divider, one dividend bit per cycle
    assign rem_sh  = {r_rem, r_dvd[DIV_DW-1]};
    assign dvs_ext = {1'b0, r_dvs};
    assign rem_ge  = (rem_sh >= dvs_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= DIV_CNT_W'(DIV_DW);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem       <= '0;
            r_quo       <= '0;
            r_div_ratio <= (r_mode == MODE_RATIO);
            if (r_mode == MODE_RATIO) begin
                r_dvd <= DIV_DW'(r_time) * DIV_DW'(SHARE_FULL);
                r_dvs <= DIV_VW'(r_quick_time) + DIV_VW'(r_time);
            end else begin
                r_dvd <= DIV_DW'(r_iter);
                r_dvs <= DIV_VW'(r_period) + DIV_VW'(1);
            end
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? DIV_VW'(rem_sh - dvs_ext) : DIV_VW'(rem_sh);
            r_quo <= {r_quo[WL_W-2:0], rem_ge};
            r_dvd <= {r_dvd[DIV_DW-2:0], 1'b0};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_share <= r_share;
            r_out_tuned <= r_tuned;
            r_out_stop  <= r_stop;
        end
    end

    assign o_workload  = r_out_share;
    assign o_tuned_now = r_out_tuned;
    assign o_stopped   = r_out_stop;

    `WSA_ASSERT_NXT(a_restart_clears, i_clk, i_rst_n, i_cmd.restart, !r_stop && !r_tuned && (r_quick_time == '0), "restart left tuning state behind")
    `WSA_ASSERT_IMP(a_stop_sticky, i_clk, i_rst_n, $fell(r_stop), $past(i_cmd.restart) || $past(!i_rst_n), "stop flag cleared without restart")
    `WSA_ASSERT_IMP(a_no_tune_stopped, i_clk, i_rst_n, i_cmd.tune, !r_stop, "tuning applied after stop")

endmodule

// File: sv/workload_split_autotuner.sv
// Workload split autotuner.
// Request channel i_in: opcode 0 restarts tuning state, opcode 1 reports an
// iteration with its index and measured compute time (zero = not measured).
// Result channel o_out: one result per request carrying the share to use
// next, whether this iteration was a tuning point, and the stop flag.
// Register channel i_cfg: index 0 selects the mode (1 step-down, 2 ratio,
// 3 bisection), index 1 the stable period; always ready, write only when idle.
// Flow: a request is taken only while the engine is idle. Restarts,
// stopped tuning, mode 0, the first ratio point and ratio-mode non-tuning
// iterations go from decode straight to write-back. Step-down and bisection
// iterations, and the second ratio point, run the serial divider (one bit
// per cycle over a 39-bit dividend) and a tune step before write-back.
// A finished result sits in an output register; the engine takes the next
// request while it waits, and holds a new result until the receiver drains
// the old one. Reset sets mode 1, period 10, share 100 and clears the state.
module workload_split_autotuner import wsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsa_in_if.sink    i_in,
    wsa_out_if.source o_out,
    wsa_cfg_if.sink   i_cfg
);

    // Command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // Sequencer: idle, decode, divide, tune, write back
    wsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: registers, tuning state, serial divider, result register
    wsa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (i_cfg),
        .i_opcode        (i_in.opcode),
        .i_iteration     (i_in.iteration),
        .i_measured_time (i_in.measured_time),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_workload      (o_out.workload),
        .o_tuned_now     (o_out.tuned_now),
        .o_stopped       (o_out.stopped)
    );

endmodule
